/* src/btli_pkg.sv */
// ----------------------------------------------------------------------------
// btli_pkg: shared definitions of the breakpoint table interpolator
// Table sizes, operation codes, arithmetic widths and the divider status.
// ----------------------------------------------------------------------------
package btli_pkg;

   localparam int NUM_POINTS  = 128;
   localparam int NUM_CURVES  = 32;
   localparam int VALUE_WIDTH = 32;

   localparam int IDX_W   = $clog2(NUM_POINTS);
   localparam int CADDR_W = $clog2(NUM_CURVES * NUM_POINTS);

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_LOOKUP   = 2'd0;
   localparam logic [1:0] OP_WRITE_BP = 2'd1;
   localparam logic [1:0] OP_WRITE_CV = 2'd2;

   // magnitudes of 33-bit differences, their product, and the kept quotient
   localparam int MAG_W  = 33;
   localparam int PROD_W = 65;
   localparam int QUO_W  = 34;
   localparam int CNT_W  = $clog2(QUO_W + 1);

   // result saturates to the narrower of VALUE_WIDTH and 32 bits
   localparam int SAT_BITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam int SUM_W    = QUO_W + 2;
   localparam logic signed [SUM_W-1:0] SUM_MAX =
      (SUM_W'(1) <<< (SAT_BITS - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

   typedef struct packed {
      logic done;      // one-cycle pulse: quotient is final
      logic overflow;  // quotient would not fit in QUO_W bits
   } div_status_type;

endpackage

/* src/btli_div.sv */
// ----------------------------------------------------------------------------
// btli_div: serial restoring divider
// Divides the unsigned interpolation product by the segment width, one
// quotient bit per cycle; quotients wider than QUO_W bits are flagged.
// ----------------------------------------------------------------------------
module btli_div
   import btli_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_W-1:0]    dividend,
   input  logic [MAG_W-1:0]     divisor,
   output logic [QUO_W-1:0]     quotient,
   output div_status_type       status
);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic              ovf_ff,   ovf_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [MAG_W-1:0]  rem_ff,   rem_in;
   logic [QUO_W-1:0]  dvd_ff,   dvd_in;

   logic              too_big;
   logic [MAG_W-1:0]  rem_shift;
   logic              fits;

   // quotient overflows when dividend >= divisor * 2^QUO_W
   assign too_big   = {2'b00, dividend} >= {divisor, {QUO_W{1'b0}}};
   assign rem_shift = {rem_ff[MAG_W-2:0], dvd_ff[QUO_W-1]};
   assign fits      = rem_shift >= divisor;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         ovf_in = too_big;
         if (too_big) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = CNT_W'(QUO_W);
            rem_in  = MAG_W'(dividend[PROD_W-1:QUO_W]);
            dvd_in  = dividend[QUO_W-1:0];
         end
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? (rem_shift - divisor) : rem_shift;
         dvd_in = {dvd_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign quotient        = dvd_ff;
   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;

endmodule

/* src/breakpoint_table_linear_interp.sv */
// ----------------------------------------------------------------------------
// breakpoint_table_linear_interp: breakpoint table with linear interpolation
// Sorted angle table plus coefficient curves; lookups return the
// interpolated, saturated coefficient with range flag and clamped angle.
// ----------------------------------------------------------------------------
// A write transfer (breakpoint or curve entry) gives no result. The block
// accepts nothing else while a lookup runs: states FIRST, LAST and EDGE read
// and compare the two table ends, the binary search does one halving per read
// on the single breakpoint memory port, two reads fetch the bracketing
// entries, and the serial divider forms the quotient bit by bit. A
// zero-width segment skips the divider. A finished result sits in the output
// register, so a new transfer can be taken while it waits.
module breakpoint_table_linear_interp
   import btli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // curve_select[4:0], entry_index[11:5], write_value[43:12],
   // query_angle[75:44], zero[79:76]
   input  logic [79:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[31:0], out_of_range[32], clamped_angle[64:33], zero[71:65]
   output logic [71:0] rsp_tdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FIRST = 4'd1;
   localparam logic [3:0] ST_LAST  = 4'd2;
   localparam logic [3:0] ST_EDGE  = 4'd3;
   localparam logic [3:0] ST_STEP  = 4'd4;
   localparam logic [3:0] ST_LOWER = 4'd5;
   localparam logic [3:0] ST_UPPER = 4'd6;
   localparam logic [3:0] ST_MUL   = 4'd7;
   localparam logic [3:0] ST_ACC   = 4'd8;
   localparam logic [3:0] ST_START = 4'd9;
   localparam logic [3:0] ST_WAIT  = 4'd10;
   localparam logic [3:0] ST_SUM   = 4'd11;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

   // input fields
   logic [4:0]         f_curve;
   logic [6:0]         f_entry;
   logic [31:0]        f_wval;
   logic [31:0]        f_query;
   logic [1:0]         f_op;
   logic               req_xfer;

   assign f_curve  = req_tdata[4:0];
   assign f_entry  = req_tdata[11:5];
   assign f_wval   = req_tdata[43:12];
   assign f_query  = req_tdata[75:44];
   assign f_op     = req_tuser;
   assign req_xfer = req_tvalid && req_tready;

   logic [3:0]          state_ff, state_in;
   logic [IDX_W-1:0]    lo_ff, lo_in;
   logic [IDX_W-1:0]    hi_ff, hi_in;
   logic [31:0]         q_ff;
   logic [4:0]          curve_ff;
   logic                curve_ok_ff;
   logic                below_ff, below_in;
   logic                oor_ff, oor_in;
   logic [31:0]         clamp_ff, clamp_in;
   logic [31:0]         ba_ff, ca_ff;
   logic [MAG_W-1:0]    mag_c_ff, mag_x_ff, mag_b_ff;
   logic                neg_ff, zseg_ff;
   logic [63:0]         plo_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [71:0]         rsp_data_ff, rsp_data_in;

   // memories
   logic [31:0] bp_mem [NUM_POINTS];
   logic [31:0] cv_mem [NUM_CURVES * NUM_POINTS];
   logic [31:0] bp_rd_ff;
   logic [31:0] cv_rd_ff;
   logic [IDX_W-1:0]   rd_idx;
   logic [CADDR_W-1:0] cv_rd_addr;
   logic [CADDR_W-1:0] cv_wr_addr;

   assign cv_rd_addr = CADDR_W'(curve_ff) * CADDR_W'(NUM_POINTS) + CADDR_W'(rd_idx);
   assign cv_wr_addr = CADDR_W'(f_curve) * CADDR_W'(NUM_POINTS) + CADDR_W'(f_entry);

   always_ff @(posedge clock) begin
      if (req_xfer && (f_op == OP_WRITE_BP) && (32'(f_entry) < NUM_POINTS)) begin
         bp_mem[IDX_W'(f_entry)] <= f_wval;
      end
      bp_rd_ff <= bp_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (f_op == OP_WRITE_CV) && (32'(f_entry) < NUM_POINTS)
          && (32'(f_curve) < NUM_CURVES)) begin
         cv_mem[cv_wr_addr] <= f_wval;
      end
      cv_rd_ff <= cv_mem[cv_rd_addr];
   end

   // search bounds after this cycle's compare, and the read they call for
   logic [IDX_W-1:0] lo_n, hi_n, mid_n;
   logic             span_open;
   logic             q_gt_rd;

   assign q_gt_rd = $signed(q_ff) > $signed(bp_rd_ff);

   // midpoint of the bounds that are registered now (the one being compared)
   function automatic logic [IDX_W-1:0] mid_reg_idx();
      logic [IDX_W:0] s;
      s = {1'b0, lo_ff} + {1'b0, hi_ff};
      return s[IDX_W:1];
   endfunction

   always_comb begin
      lo_n = lo_ff;
      hi_n = hi_ff;
      if (state_ff == ST_STEP) begin
         if (q_gt_rd) begin
            lo_n = mid_reg_idx();
         end else begin
            hi_n = mid_reg_idx();
         end
      end
   end

   logic [IDX_W:0] sum_n;
   assign sum_n     = {1'b0, lo_n} + {1'b0, hi_n};
   assign mid_n     = sum_n[IDX_W:1];
   assign span_open = (hi_n - lo_n) > IDX_W'(1);

   // difference terms for the interpolation
   logic signed [32:0] dc, dx, db;
   logic [31:0]        cb_v;

   assign cb_v = curve_ok_ff ? cv_rd_ff : 32'd0;
   assign dc   = $signed({cb_v[31], cb_v}) - $signed({ca_ff[31], ca_ff});
   assign dx   = $signed({q_ff[31], q_ff}) - $signed({ba_ff[31], ba_ff});
   assign db   = $signed({bp_rd_ff[31], bp_rd_ff}) - $signed({ba_ff[31], ba_ff});

   // divider
   logic [QUO_W-1:0] quotient;
   div_status_type   div_status;
   logic             div_start;

   assign div_start = (state_ff == ST_START) && !zseg_ff;

   btli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (mag_b_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   // product assembly: low 32x32 partial product plus the top-bit terms
   logic [PROD_W-1:0] t_c, t_x, t_cx;
   assign t_c  = mag_c_ff[MAG_W-1] ? {1'b0, mag_x_ff[31:0], 32'd0} : '0;
   assign t_x  = mag_x_ff[MAG_W-1] ? {1'b0, mag_c_ff[31:0], 32'd0} : '0;
   assign t_cx = (mag_c_ff[MAG_W-1] && mag_x_ff[MAG_W-1]) ? {1'b1, 64'd0} : '0;

   // final sum and saturation
   logic signed [SUM_W-1:0] sum_val, sat_val;
   logic [31:0]             res_val;

   always_comb begin
      sum_val = $signed({{(SUM_W-32){ca_ff[31]}}, ca_ff});
      if (neg_ff) begin
         sum_val = sum_val - $signed({2'b00, quotient});
      end else begin
         sum_val = sum_val + $signed({2'b00, quotient});
      end
      if (zseg_ff) begin
         sat_val = $signed({{(SUM_W-32){ca_ff[31]}}, ca_ff});
      end else if (div_status.overflow) begin
         sat_val = neg_ff ? SUM_MIN : SUM_MAX;
      end else if (sum_val > SUM_MAX) begin
         sat_val = SUM_MAX;
      end else if (sum_val < SUM_MIN) begin
         sat_val = SUM_MIN;
      end else begin
         sat_val = sum_val;
      end
      res_val = sat_val[31:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      below_in     = below_ff;
      oor_in       = oor_ff;
      clamp_in     = clamp_ff;
      rd_idx       = lo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            lo_in = '0;
            hi_in = LAST_IDX;
            if (req_xfer && (f_op == OP_LOOKUP)) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            rd_idx   = '0;
            state_in = ST_LAST;
         end
         ST_LAST: begin
            rd_idx   = LAST_IDX;
            below_in = $signed(q_ff) < $signed(bp_rd_ff);
            clamp_in = bp_rd_ff;
            state_in = ST_EDGE;
         end
         ST_EDGE, ST_STEP: begin
            if (state_ff == ST_EDGE) begin
               oor_in = below_ff || q_gt_rd;
               if (!below_ff) begin
                  clamp_in = q_gt_rd ? bp_rd_ff : q_ff;
               end
            end
            lo_in = lo_n;
            hi_in = hi_n;
            if (span_open) begin
               rd_idx   = mid_n;
               state_in = ST_STEP;
            end else begin
               rd_idx   = lo_n;
               state_in = ST_LOWER;
            end
         end
         ST_LOWER: begin
            rd_idx   = hi_ff;
            state_in = ST_UPPER;
         end
         ST_UPPER: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = zseg_ff ? ST_SUM : ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, clamp_ff, oor_ff, res_val};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      below_ff    <= below_in;
      oor_ff      <= oor_in;
      clamp_ff    <= clamp_in;
      rsp_data_ff <= rsp_data_in;
      if (req_xfer && (f_op == OP_LOOKUP)) begin
         q_ff        <= f_query;
         curve_ff    <= f_curve;
         curve_ok_ff <= 32'(f_curve) < NUM_CURVES;
      end
      if (state_ff == ST_LOWER) begin
         ba_ff <= bp_rd_ff;
         ca_ff <= curve_ok_ff ? cv_rd_ff : 32'd0;
      end
      if (state_ff == ST_UPPER) begin
         mag_c_ff <= dc[32] ? MAG_W'(-dc) : MAG_W'(dc);
         mag_x_ff <= dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
         mag_b_ff <= db[32] ? MAG_W'(-db) : MAG_W'(db);
         neg_ff   <= dc[32] ^ dx[32] ^ db[32];
         zseg_ff  <= (db == 33'sd0);
      end
      if (state_ff == ST_MUL) begin
         plo_ff <= mag_c_ff[31:0] * mag_x_ff[31:0];
      end
      if (state_ff == ST_ACC) begin
         prod_ff <= {1'b0, plo_ff} + t_c + t_x + t_cx;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* bench/tb_breakpoint_table_linear_interp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breakpoint_table_linear_interp: self-checking bench of the table lookup
// Loads breakpoint tables of several shapes and coefficient curves over the
// request stream, then issues lookups. Every lookup is predicted from a local
// copy of both tables, and each response transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_breakpoint_table_linear_interp
   import btli_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         WATCHDOG_LIMIT    = 4000;
   localparam int         LONG_STALL_CYCLES = 300;
   localparam int         DRAIN_CYCLES      = 64;
   localparam longint     INT32_HI = 64'sd2147483647;
   localparam longint     INT32_LO = -64'sd2147483648;

   typedef enum {SHAPE_UNIT, SHAPE_RAMP, SHAPE_DENSE, SHAPE_STEEP_ENDS, SHAPE_FLAT}
      table_shape_type;

   typedef struct packed {
      logic [31:0] value;
      logic        out_of_range;
      logic [31:0] clamped;
   } lookup_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // curve_select[4:0], entry_index[11:5], write_value[43:12],
   // query_angle[75:44], zero[79:76]
   logic [79:0] req_tdata  = '0;
   // operation[1:0]
   logic [1:0]  req_tuser  = OP_LOOKUP;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // result_value[31:0], out_of_range[32], clamped_angle[64:33], zero[71:65]
   logic [71:0] rsp_tdata;

   // local copy of the tables
   logic signed [31:0] angle_mem [NUM_POINTS];
   logic signed [31:0] coef_mem [NUM_CURVES][NUM_POINTS];
   bit                 coef_loaded [NUM_CURVES][NUM_POINTS];

   lookup_rsp_type pending_lookups [$];
   int          items_sent     = 0;
   int          error_count    = 0;
   int          quiet_cycles   = 0;
   bit          idle_enable    = 1'b0;
   bit          long_stall_req = 1'b0;

   breakpoint_table_linear_interp i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic void find_segment(input logic signed [31:0] q,
                                        output int lo_idx, output int hi_idx);
      int mid;
      lo_idx = 0;
      hi_idx = NUM_POINTS - 1;
      while (hi_idx - lo_idx > 1) begin
         mid = (lo_idx + hi_idx) / 2;
         if (q > angle_mem[mid]) lo_idx = mid;
         else hi_idx = mid;
      end
   endfunction

   function automatic lookup_rsp_type interpolate_lookup(logic [4:0] curve,
                                                         logic signed [31:0] q);
      int           lo_idx, hi_idx;
      longint       ba, bb, ca, cb, dc, dx, db, sum, sat_hi, sat_lo;
      logic [63:0]  mag_dc, mag_dx, mag_db;
      logic [127:0] prod, quo;
      logic         neg;
      lookup_rsp_type r;
      find_segment(q, lo_idx, hi_idx);
      ba = angle_mem[lo_idx];
      bb = angle_mem[hi_idx];
      ca = coef_mem[curve][lo_idx];
      cb = coef_mem[curve][hi_idx];
      if (bb == ba) begin
         sum = ca;
      end else begin
         dc = cb - ca;
         dx = longint'(q) - ba;
         db = bb - ba;
         neg = ((dc < 0) != (dx < 0)) != (db < 0);
         mag_dc = (dc < 0) ? 64'(-dc) : 64'(dc);
         mag_dx = (dx < 0) ? 64'(-dx) : 64'(dx);
         mag_db = (db < 0) ? 64'(-db) : 64'(db);
         prod = {64'd0, mag_dc} * {64'd0, mag_dx};
         quo  = prod / {64'd0, mag_db};
         if (dc == 0 || dx == 0) begin
            sum = ca;
         end else if (quo > (128'd1 << 40)) begin
            // quotient too wide: push the sum far past either rail
            sum = neg ? -(longint'(1) <<< 62) : (longint'(1) <<< 62) - 1;
         end else begin
            sum = neg ? ca - longint'(quo[63:0]) : ca + longint'(quo[63:0]);
         end
      end
      sat_hi = (longint'(1) <<< (SAT_BITS - 1)) - 1;
      sat_lo = -sat_hi - 1;
      if (sum > sat_hi) sum = sat_hi;
      if (sum < sat_lo) sum = sat_lo;
      r.value = sum[31:0];
      // below the first breakpoint is tested first
      if (q < angle_mem[0]) begin
         r.clamped = angle_mem[0];
         r.out_of_range = 1'b1;
      end else if (q > angle_mem[NUM_POINTS-1]) begin
         r.clamped = angle_mem[NUM_POINTS-1];
         r.out_of_range = 1'b1;
      end else begin
         r.clamped = q;
         r.out_of_range = 1'b0;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // value generators
   // ------------------------------------------------------------------------
   function automatic logic [31:0] rand_value();
      logic [20:0] near_zero;
      near_zero = 21'($urandom);
      case ($urandom_range(0, 4))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2: return $urandom;
         default: return {{11{near_zero[20]}}, near_zero};
      endcase
   endfunction

   function automatic logic [31:0] pick_between(longint a, longint b);
      logic [63:0] r;
      r = {$urandom, $urandom};
      if (b < a) return rand_value();
      return 32'(a + longint'(r % 64'(b - a + 1)));
   endfunction

   function automatic logic [31:0] rand_query();
      int idx;
      idx = $urandom_range(0, NUM_POINTS - 1);
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3: return 32'(longint'(angle_mem[idx]) + longint'($urandom_range(0, 2)) - 1);
         default: return pick_between(angle_mem[0], angle_mem[NUM_POINTS-1]);
      endcase
   endfunction

   // mostly keep the table sorted; now and then drop in an arbitrary angle
   function automatic logic [31:0] rand_angle(int idx);
      longint lo_n, hi_n;
      if ($urandom_range(0, 3) == 0) return rand_value();
      lo_n = (idx == 0) ? longint'(angle_mem[0]) - 4096 : longint'(angle_mem[idx-1]);
      hi_n = (idx == NUM_POINTS - 1) ? longint'(angle_mem[idx]) + 4096
                                     : longint'(angle_mem[idx+1]);
      if (lo_n < INT32_LO) lo_n = INT32_LO;
      if (hi_n > INT32_HI) hi_n = INT32_HI;
      return pick_between(lo_n, hi_n);
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_item(logic [1:0] op, logic [4:0] curve, logic [6:0] entry,
                            logic [31:0] wdata, logic [31:0] query);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, query, wdata, entry, curve};
      do @(posedge clock); while (req_tready !== 1'b1);
      case (op)
         OP_LOOKUP:   pending_lookups.push_back(interpolate_lookup(curve, query));
         OP_WRITE_BP: angle_mem[entry] = wdata;
         OP_WRITE_CV: begin
            coef_mem[curve][entry] = wdata;
            coef_loaded[curve][entry] = 1'b1;
         end
         default: ;
      endcase
      if (op != OP_UNUSED) items_sent++;
   endtask

   // fill the bracketing curve entries first so no lookup reads an empty entry
   task automatic lookup(logic [4:0] curve, logic [31:0] q);
      int lo_idx, hi_idx;
      find_segment(q, lo_idx, hi_idx);
      if (!coef_loaded[curve][lo_idx])
         send_item(OP_WRITE_CV, curve, 7'(lo_idx), rand_value(), $urandom);
      if (!coef_loaded[curve][hi_idx])
         send_item(OP_WRITE_CV, curve, 7'(hi_idx), rand_value(), $urandom);
      send_item(OP_LOOKUP, curve, 7'($urandom), $urandom, q);
   endtask

   task automatic load_table(table_shape_type shape);
      longint level;
      int     i;
      level = 0;
      for (i = 0; i < NUM_POINTS; i++) begin
         case (shape)
            SHAPE_UNIT: begin
               // 1.0 steps, zero-width low segment, one-LSB top segment
               if (i == 0) level = -63 * 65536;
               else if (i == NUM_POINTS - 1) level = level + 1;
               else level = longint'(i - 64) * 65536;
            end
            SHAPE_RAMP: begin
               if (i == 0) level = -longint'($urandom_range(0, 1 << 28));
               else level += $urandom_range(0, 1 << 22);
            end
            SHAPE_DENSE: begin
               if (i == 0) level = longint'($signed($urandom));
               else level += $urandom_range(0, 3);
            end
            SHAPE_STEEP_ENDS: begin
               if (i == 0) level = -(longint'(1) <<< 29);
               else if (i == 1 || i == NUM_POINTS - 1) level += 1;
               else level += $urandom_range(1, 1 << 22);
            end
            default: begin
               if (i == 0) level = longint'($signed(rand_value()));
            end
         endcase
         if (level > INT32_HI) level = INT32_HI;
         send_item(OP_WRITE_BP, 5'($urandom), 7'(i), level[31:0], $urandom);
      end
   endtask

   task automatic random_mix(int n);
      int          goal, pick, idx;
      logic [4:0]  curve;
      goal = items_sent + n;
      while (items_sent < goal) begin
         pick  = $urandom_range(0, 19);
         curve = 5'($urandom);
         idx   = $urandom_range(0, NUM_POINTS - 1);
         if (pick < 11)
            lookup(curve, rand_query());
         else if (pick < 15)
            send_item(OP_WRITE_CV, curve, 7'(idx), rand_value(), $urandom);
         else if (pick < 19)
            send_item(OP_WRITE_BP, curve, 7'(idx), rand_angle(idx), $urandom);
         else
            send_item(OP_UNUSED, curve, 7'(idx), $urandom, $urandom);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_cases();
      load_table(SHAPE_UNIT);
      // plain interpolation: 1.0 -> 3.0 over [0.0, 1.0]
      send_item(OP_WRITE_CV, 5'd0, 7'd64, 32'h0001_0000, 32'h0);
      send_item(OP_WRITE_CV, 5'd0, 7'd65, 32'h0003_0000, 32'h0);
      lookup(5'd0, 32'h0000_8000);
      lookup(5'd0, 32'h0000_0000);
      // zero-width low segment, below the table and exactly at its start
      send_item(OP_WRITE_CV, 5'd1, 7'd0, 32'h7FFF_FFFF, 32'h0);
      send_item(OP_WRITE_CV, 5'd1, 7'd1, 32'h8000_0000, 32'h0);
      lookup(5'd1, 32'h8000_0000);
      lookup(5'd1, 32'hFFC1_0000);
      // extrapolate over the one-LSB top segment: overflow both ways
      send_item(OP_WRITE_CV, 5'd2, 7'd126, 32'h0000_0000, 32'h0);
      send_item(OP_WRITE_CV, 5'd2, 7'd127, 32'h0001_0000, 32'h0);
      lookup(5'd2, 32'h7FFF_FFFF);
      send_item(OP_WRITE_CV, 5'd3, 7'd126, 32'h0000_0000, 32'h0);
      send_item(OP_WRITE_CV, 5'd3, 7'd127, 32'hFFFF_0000, 32'h0);
      lookup(5'd3, 32'h7FFF_FFFF);
      // small quotient, but the sum runs past the positive rail
      send_item(OP_WRITE_CV, 5'd4, 7'd126, 32'h7FFF_0000, 32'h0);
      send_item(OP_WRITE_CV, 5'd4, 7'd127, 32'h7FFF_0001, 32'h0);
      lookup(5'd4, 32'h7FFF_FFFF);
      // flat curve segment, and a query at the last breakpoint
      send_item(OP_WRITE_CV, 5'd31, 7'd126, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(OP_WRITE_CV, 5'd31, 7'd127, 32'h8000_0000, 32'hFFFF_FFFF);
      lookup(5'd31, 32'h7FFF_FFFF);
      lookup(5'd31, 32'h003E_0001);
      send_item(OP_UNUSED, 5'd31, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic(table_shape_type shape, int n);
      load_table(shape);
      random_mix(n);
   endtask

   // hold the response side off while lookups keep coming
   task automatic test_output_stall();
      int i;
      load_table(SHAPE_RAMP);
      long_stall_req = 1'b1;
      for (i = 0; i < 12; i++) lookup(5'($urandom), rand_query());
   endtask

   task automatic test_unpaced_traffic();
      idle_enable = 1'b0;
      random_mix(150);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lookup_rsp_type want;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_lookups.size() == 0) begin
            $error("response transfer with no lookup pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $error("result_value expected %h actual %h", want.value, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[32] !== want.out_of_range) begin
               $error("out_of_range expected %b actual %b", want.out_of_range,
                      rsp_tdata[32]);
               error_count++;
            end
            if (rsp_tdata[64:33] !== want.clamped) begin
               $error("clamped_angle expected %h actual %h", want.clamped,
                      rsp_tdata[64:33]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_enable = 1'b1;
      test_directed_cases();
      test_random_traffic(SHAPE_RAMP, 330);
      test_random_traffic(SHAPE_DENSE, 300);
      test_random_traffic(SHAPE_STEEP_ENDS, 250);
      test_random_traffic(SHAPE_FLAT, 50);
      test_output_stall();
      test_unpaced_traffic();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
